@@ sv/irrigation_valve_sequencer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the irrigation valve sequencer checker
// ---------------------------------------------------------------------------
`ifndef IRRIGATION_VALVE_SEQUENCER_ASSERT_SVH
`define IRRIGATION_VALVE_SEQUENCER_ASSERT_SVH

// Clocked assertion, masked while reset is held
`define IVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset
`define IVS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/ivs_pkg.sv @@
// ---------------------------------------------------------------------------
// ivs_pkg
// Shared types, codes and helpers of the irrigation valve sequencer.
// ---------------------------------------------------------------------------
package ivs_pkg;

  localparam int PLANTS_DEFAULT = 4;
  localparam int MASK_W         = 4;
  localparam int LEVEL_W        = 10;
  localparam int SEC_W          = 16;
  localparam int CFG_IDX_W      = 3;

  localparam logic [LEVEL_W-1:0] RST_DRY_LEVEL    = 10'd300;
  localparam logic [LEVEL_W-1:0] RST_WET_LEVEL    = 10'd600;
  localparam logic [SEC_W-1:0]   RST_BURST_SEC    = 16'd15;
  localparam logic [SEC_W-1:0]   RST_REST_SEC     = 16'd3600;
  localparam logic [SEC_W-1:0]   RST_PAUSE_SEC    = 16'd60;
  localparam logic [SEC_W-1:0]   RST_SETTLE_SEC   = 16'd30;
  localparam logic [SEC_W-1:0]   RST_INTERVAL_SEC = 16'd60;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SAMPLE   = 2'd1,
    CMD_SETTINGS = 2'd2,
    CMD_FLAGS    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEF_DRY   = 3'd0,
    REG_DEF_WET   = 3'd1,
    REG_DEF_BURST = 3'd2,
    REG_DEF_REST  = 3'd3,
    REG_PAUSE     = 3'd4,
    REG_SETTLE    = 3'd5,
    REG_INTERVAL  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUMP,
    ST_LATCH,
    ST_WALK,
    ST_ABORT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic bump;
    logic latch;
    logic walk;
    logic abort;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
  } ctrl_status_t;

  function automatic logic [SEC_W-1:0] sat_inc(input logic [SEC_W-1:0] t);
    return (t == {SEC_W{1'b1}}) ? t : t + 1'b1;
  endfunction

endpackage

@@ sv/ivs_datapath.sv @@
// ---------------------------------------------------------------------------
// ivs_datapath
// Settings, per-plant state, timers and the result register. Each step is
// issued by the controller; the walk handles one plant per cycle.
// ---------------------------------------------------------------------------
module ivs_datapath #(
  parameter int PLANTS = ivs_pkg::PLANTS_DEFAULT,
  parameter int IW     = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ivs_pkg::ctrl_cmd_t                cmd_ctl,
  input  logic [IW-1:0]                     walk_idx,
  output ivs_pkg::ctrl_status_t             status,
  input  logic                              cfg_valid,
  input  logic [ivs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ivs_pkg::SEC_W-1:0]         cfg_data,
  input  logic [1:0]                        cmd,
  input  logic [1:0]                        plant,
  input  logic [ivs_pkg::LEVEL_W-1:0]       sample_level,
  input  logic [ivs_pkg::LEVEL_W-1:0]       dry_threshold,
  input  logic [ivs_pkg::LEVEL_W-1:0]       wet_threshold,
  input  logic [ivs_pkg::SEC_W-1:0]         burst_seconds,
  input  logic [ivs_pkg::SEC_W-1:0]         rest_seconds,
  input  logic [ivs_pkg::MASK_W-1:0]        active_mask,
  input  logic [ivs_pkg::MASK_W-1:0]        override_mask,
  input  logic                              pump_force,
  output logic [ivs_pkg::MASK_W-1:0]        valve_mask,
  output logic                              pump_on,
  output logic                              fresh_data,
  output logic [ivs_pkg::MASK_W-1:0]        manual_done_mask
);
  import ivs_pkg::*;

  localparam int MW = (PLANTS > MASK_W) ? PLANTS : MASK_W;

  // configuration registers
  logic [LEVEL_W-1:0] def_dry, def_wet;
  logic [SEC_W-1:0]   def_burst, def_rest, pause_sec, settle_sec, interval_sec;

  // per-plant state
  logic [LEVEL_W-1:0] latest   [PLANTS];
  logic [LEVEL_W-1:0] moist    [PLANTS];
  logic [SEC_W-1:0]   elapsed  [PLANTS];
  logic [LEVEL_W-1:0] p_dry    [PLANTS];
  logic [LEVEL_W-1:0] p_wet    [PLANTS];
  logic [SEC_W-1:0]   p_burst  [PLANTS];
  logic [SEC_W-1:0]   p_rest   [PLANTS];
  logic [PLANTS-1:0]  valve_bits, pausing_bits, manual_bits, done_bits;

  logic [MASK_W-1:0]  active_flags, over_flags;
  logic               force_flag;
  logic [SEC_W-1:0]   since_read, since_pump_off;
  logic               pump_was_active;

  // per-tick scratch
  logic latched, changed, already;

  logic [MW-1:0]     act_ext, over_ext, valve_ext, done_ext;
  logic [PLANTS-1:0] act_vec, over_vec, abort_vec;
  logic              pump_active, latch_ok, plant_ok, thr_bad;
  logic [IW-1:0]     pidx;

  // walk decode for the plant at walk_idx
  logic w_en, w_man, need;
  logic w_close, w_finish, w_reopen, w_pdone, w_start, w_idone;

  assign status.is_tick = (cmd == CMD_TICK);

  always_comb begin
    act_ext   = MW'(active_flags);
    over_ext  = MW'(over_flags);
    act_vec   = act_ext[PLANTS-1:0];
    over_vec  = over_ext[PLANTS-1:0];
    abort_vec = manual_bits & ~over_vec;
    valve_ext = MW'(valve_bits);
    done_ext  = MW'(done_bits);

    pump_active = (|valve_bits) || force_flag;
    latch_ok    = !pump_active && (pausing_bits == '0) &&
                  (since_pump_off >= settle_sec) && (since_read >= interval_sec);

    plant_ok = (32'(plant) < PLANTS);
    pidx     = IW'(plant);
    thr_bad  = (dry_threshold == '0) || (wet_threshold == '0) ||
               (dry_threshold >= wet_threshold);

    w_man = over_vec[walk_idx];
    w_en  = act_vec[walk_idx] || w_man;
    if (w_man) begin
      need = moist[walk_idx] < p_wet[walk_idx];
    end else begin
      need = (moist[walk_idx] < p_dry[walk_idx]) &&
             (elapsed[walk_idx] >= p_rest[walk_idx]);
    end
    w_close  = w_en && valve_bits[walk_idx] &&
               (elapsed[walk_idx] >= p_burst[walk_idx]);
    w_finish = w_en && !valve_bits[walk_idx] && pausing_bits[walk_idx] &&
               (elapsed[walk_idx] >= pause_sec);
    w_reopen = w_finish && (latest[walk_idx] < p_wet[walk_idx]) && !already;
    w_pdone  = w_finish && !w_reopen && manual_bits[walk_idx];
    w_start  = w_en && !valve_bits[walk_idx] && !pausing_bits[walk_idx] &&
               need && !already;
    w_idone  = w_en && !valve_bits[walk_idx] && !pausing_bits[walk_idx] &&
               w_man && !need;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      def_dry      <= RST_DRY_LEVEL;
      def_wet      <= RST_WET_LEVEL;
      def_burst    <= RST_BURST_SEC;
      def_rest     <= RST_REST_SEC;
      pause_sec    <= RST_PAUSE_SEC;
      settle_sec   <= RST_SETTLE_SEC;
      interval_sec <= RST_INTERVAL_SEC;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEF_DRY:   def_dry      <= cfg_data[LEVEL_W-1:0];
        REG_DEF_WET:   def_wet      <= cfg_data[LEVEL_W-1:0];
        REG_DEF_BURST: def_burst    <= cfg_data;
        REG_DEF_REST:  def_rest     <= cfg_data;
        REG_PAUSE:     pause_sec    <= cfg_data;
        REG_SETTLE:    settle_sec   <= cfg_data;
        REG_INTERVAL:  interval_sec <= cfg_data;
        default: ;
      endcase
    end
  end

  // plant state and timers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANTS; i++) begin
        latest[i]  <= '0;
        moist[i]   <= '0;
        elapsed[i] <= '0;
        p_dry[i]   <= RST_DRY_LEVEL;
        p_wet[i]   <= RST_WET_LEVEL;
        p_burst[i] <= RST_BURST_SEC;
        p_rest[i]  <= RST_REST_SEC;
      end
      valve_bits      <= '0;
      pausing_bits    <= '0;
      manual_bits     <= '0;
      done_bits       <= '0;
      active_flags    <= '0;
      over_flags      <= '0;
      force_flag      <= 1'b0;
      since_read      <= '0;
      since_pump_off  <= '0;
      pump_was_active <= 1'b0;
      latched         <= 1'b0;
      changed         <= 1'b0;
      already         <= 1'b0;
    end else if (cmd_ctl.accept) begin
      latched   <= 1'b0;
      changed   <= 1'b0;
      done_bits <= '0;
      unique case (cmd)
        CMD_SAMPLE: begin
          if (plant_ok) latest[pidx] <= sample_level;
        end
        CMD_SETTINGS: begin
          if (plant_ok) begin
            p_dry[pidx]   <= thr_bad ? def_dry : dry_threshold;
            p_wet[pidx]   <= thr_bad ? def_wet : wet_threshold;
            p_burst[pidx] <= (burst_seconds == '0) ? def_burst : burst_seconds;
            p_rest[pidx]  <= rest_seconds;
          end
        end
        CMD_FLAGS: begin
          active_flags <= active_mask;
          over_flags   <= override_mask;
          force_flag   <= pump_force;
        end
        default: ;
      endcase
    end else if (cmd_ctl.bump) begin
      since_read <= sat_inc(since_read);
      for (int i = 0; i < PLANTS; i++) elapsed[i] <= sat_inc(elapsed[i]);
      // pump just switched off: restart the settle timer
      since_pump_off  <= (pump_was_active && !pump_active) ? '0 : sat_inc(since_pump_off);
      pump_was_active <= pump_active;
    end else if (cmd_ctl.latch) begin
      if (latch_ok) begin
        for (int i = 0; i < PLANTS; i++) moist[i] <= latest[i];
        since_read <= '0;
        latched    <= 1'b1;
      end
      already <= |valve_bits;
    end else if (cmd_ctl.walk) begin
      if (w_close || w_finish || w_start) elapsed[walk_idx] <= '0;
      if (w_close) begin
        valve_bits[walk_idx]   <= 1'b0;
        pausing_bits[walk_idx] <= 1'b1;
        changed                <= 1'b1;
      end
      if (w_finish) begin
        moist[walk_idx]        <= latest[walk_idx];
        pausing_bits[walk_idx] <= 1'b0;
        latched                <= 1'b1;
      end
      if (w_reopen || w_start) begin
        valve_bits[walk_idx] <= 1'b1;
        changed              <= 1'b1;
        already              <= 1'b1;
      end
      if (w_start) manual_bits[walk_idx] <= w_man;
      if (w_pdone) manual_bits[walk_idx] <= 1'b0;
      if (w_pdone || w_idone) done_bits[walk_idx] <= 1'b1;
    end else if (cmd_ctl.abort) begin
      // released overrides cancel their manual cycle
      if (|(valve_bits & abort_vec)) changed <= 1'b1;
      valve_bits   <= valve_bits & ~abort_vec;
      pausing_bits <= pausing_bits & ~abort_vec;
      manual_bits  <= manual_bits & ~abort_vec;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_ctl.load_out) begin
      valve_mask       <= valve_ext[MASK_W-1:0];
      pump_on          <= pump_active;
      fresh_data       <= latched || changed;
      manual_done_mask <= done_ext[MASK_W-1:0];
    end
  end

endmodule

@@ sv/ivs_controller.sv @@
// ---------------------------------------------------------------------------
// ivs_controller
// Sequencing state machine: accept, timer bump, routine latch, plant walk,
// override abort and hand-off to the result register.
// ---------------------------------------------------------------------------
module ivs_controller #(
  parameter int PLANTS = ivs_pkg::PLANTS_DEFAULT,
  parameter int IW     = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ivs_pkg::ctrl_status_t status,
  output ivs_pkg::ctrl_cmd_t    cmd_ctl,
  output logic [IW-1:0]         walk_idx
);
  import ivs_pkg::*;

  state_t        state, state_next;
  logic          last_plant;
  logic [IW-1:0] walk_idx_next;
  logic          out_valid_next;

  assign last_plant = (walk_idx == IW'(PLANTS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = status.is_tick ? ST_BUMP : ST_DONE;
      ST_BUMP:  state_next = ST_LATCH;
      ST_LATCH: state_next = ST_WALK;
      ST_WALK:  if (last_plant) state_next = ST_ABORT;
      ST_ABORT: state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ctl          = '0;
    in_ready         = (state == ST_IDLE);
    cmd_ctl.accept   = in_ready && in_valid;
    cmd_ctl.bump     = (state == ST_BUMP);
    cmd_ctl.latch    = (state == ST_LATCH);
    cmd_ctl.walk     = (state == ST_WALK);
    cmd_ctl.abort    = (state == ST_ABORT);
    cmd_ctl.load_out = (state == ST_DONE) && (!out_valid || out_ready);

    walk_idx_next = walk_idx;
    if (cmd_ctl.latch) walk_idx_next = '0;
    else if (cmd_ctl.walk && !last_plant) walk_idx_next = walk_idx + 1'b1;

    if (cmd_ctl.load_out) out_valid_next = 1'b1;
    else if (out_ready)   out_valid_next = 1'b0;
    else                  out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      walk_idx  <= walk_idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ sv/irrigation_valve_sequencer.sv @@
// A tick passes, in order, the timer bump, the routine latch, the walk over each plant
// in turn, the abort pass and the load of the result register. Other commands go
// from acceptance straight to the load. Transactions are taken one at a time, only
// while idle; the next transaction is taken while a result waits, and then waits
// for out_ready.
// Reset (rst, synchronous) restores the default settings and clears all state but the result data.
// ---------------------------------------------------------------------------
// irrigation_valve_sequencer
// Multi-plant watering sequencer: controller plus datapath.
// ---------------------------------------------------------------------------
module irrigation_valve_sequencer #(
  parameter int PLANTS = ivs_pkg::PLANTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [1:0]                    plant,
  input  logic [ivs_pkg::LEVEL_W-1:0]   sample_level,
  input  logic [ivs_pkg::LEVEL_W-1:0]   dry_threshold,
  input  logic [ivs_pkg::LEVEL_W-1:0]   wet_threshold,
  input  logic [ivs_pkg::SEC_W-1:0]     burst_seconds,
  input  logic [ivs_pkg::SEC_W-1:0]     rest_seconds,
  input  logic [ivs_pkg::MASK_W-1:0]    active_mask,
  input  logic [ivs_pkg::MASK_W-1:0]    override_mask,
  input  logic                          pump_force,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ivs_pkg::MASK_W-1:0]    valve_mask,
  output logic                          pump_on,
  output logic                          fresh_data,
  output logic [ivs_pkg::MASK_W-1:0]    manual_done_mask,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ivs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ivs_pkg::SEC_W-1:0]     cfg_data
);
  import ivs_pkg::*;

  localparam int IW = (PLANTS > 1) ? $clog2(PLANTS) : 1;

  ctrl_cmd_t     cmd_ctl;
  ctrl_status_t  status;
  logic [IW-1:0] walk_idx;

  assign cfg_ready = 1'b1;

  ivs_controller #(.PLANTS(PLANTS), .IW(IW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd_ctl   (cmd_ctl),
    .walk_idx  (walk_idx)
  );

  ivs_datapath #(.PLANTS(PLANTS), .IW(IW)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd_ctl          (cmd_ctl),
    .walk_idx         (walk_idx),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .plant            (plant),
    .sample_level     (sample_level),
    .dry_threshold    (dry_threshold),
    .wet_threshold    (wet_threshold),
    .burst_seconds    (burst_seconds),
    .rest_seconds     (rest_seconds),
    .active_mask      (active_mask),
    .override_mask    (override_mask),
    .pump_force       (pump_force),
    .valve_mask       (valve_mask),
    .pump_on          (pump_on),
    .fresh_data       (fresh_data),
    .manual_done_mask (manual_done_mask)
  );

endmodule

@@ sv/ivs_checker.sv @@
// ---------------------------------------------------------------------------
// ivs_checker
// Port-level assertions for the irrigation valve sequencer, bound to the top.
// ---------------------------------------------------------------------------
`include "irrigation_valve_sequencer_assert.svh"

module ivs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ivs_pkg::MASK_W-1:0] valve_mask,
  input logic                       pump_on,
  input logic [ivs_pkg::MASK_W-1:0] manual_done_mask
);
  import ivs_pkg::*;

  `IVS_ASSERT_RST(a_rst_no_out, rst |=> !out_valid, "result valid after reset")
  `IVS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `IVS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(valve_mask), "valve mask moved while stalled")
  // while a result is valid, at most one valve is open, and an open valve drives the pump
  `IVS_ASSERT(a_one_valve, out_valid |-> $onehot0(valve_mask) && (valve_mask == '0 || pump_on), "valve mask or pump inconsistent")
  // a finished or declined manual cycle leaves its valve shut
  `IVS_ASSERT(a_done_shut, out_valid |-> (manual_done_mask & valve_mask) == '0, "done plant has open valve")

endmodule

bind irrigation_valve_sequencer ivs_checker u_ivs_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .valve_mask       (valve_mask),
  .pump_on          (pump_on),
  .manual_done_mask (manual_done_mask)
);
